// ----- sv/rbia_pkg.sv -----
// Shared types and constants for the rotating bitmap index allocator.
`timescale 1ns / 1ps

package rbia_pkg;

	// Field widths of the request and response transactions.
	localparam int INDEX_W    = 12;
	localparam int BIT_W      = 6;
	localparam int WORD_BITS  = 64;
	localparam int TDATA_W    = 16;

	// Request kind carried on the slave-side tuser.
	typedef enum logic {
		ACT_ALLOC   = 1'b0,
		ACT_RELEASE = 1'b1
	} action_t;

	// Response status carried on the master-side tuser.
	typedef enum logic {
		STATUS_OK        = 1'b0,
		STATUS_EXHAUSTED = 1'b1
	} status_t;

	typedef logic [WORD_BITS-1:0] map_word_t;

endpackage

// ----- sv/rotating_bitmap_index_allocator.sv -----
// Rotating bitmap index allocator: free-index bitmap store with round-robin word choice.
`timescale 1ns / 1ps

// Channel  Direction  Ports                              Contents
// -------  ---------  ---------------------------------  -----------------------------------
// s_*      in         s_tvalid s_tready s_tdata s_tuser  tdata: release_index; tuser: action
// m_*      out        m_tvalid m_tready m_tdata m_tuser  tdata: granted_index; tuser: status
//
// The block takes one transaction per clock cycle unless the response side stalls, and
// returns each response through stage one and the response register. Stage one holds the
// request together with the bitmap word read from the store; the find-first-set and the
// write-back happen between stage one and the response register, and a word written in one
// cycle is forwarded to a request that read it at the same edge. After arst_n is released, a
// clearing pass writes all ones to every word, one word a cycle; s_tready stays low until it is
// done. A stalled response holds stage one; only then, with stage one full, does s_tready drop.
module rotating_bitmap_index_allocator
	import rbia_pkg::*;
#(
	parameter int WORDS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,   // [11:0] release_index, [15:12] zero
	input  logic [0:0]         s_tuser,   // [0] action
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // [11:0] granted_index, [15:12] zero
	output logic [0:0]         m_tuser    // [0] status
);

	localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);

	// Bitmap store, one bit per index, set means free.
	map_word_t free_map_q [WORDS];

	// Clearing pass after reset.
	logic            clearing_q;
	logic [AW-1:0]   clr_addr_q;

	// Rotating word pointer.
	logic [AW-1:0]   ptr_q;
	logic [AW-1:0]   ptr_next;

	// Request decode at the input.
	logic            accept;
	action_t         in_action;
	logic [INDEX_W-1:0] in_index;
	logic [BIT_W-1:0] rel_word;
	logic            rel_ok;
	logic [AW-1:0]   rd_addr;

	// Stage one.
	logic            valid_s1;
	action_t         action_s1;
	logic [BIT_W-1:0] bit_s1;
	logic [AW-1:0]   addr_s1;
	logic            rel_ok_s1;
	map_word_t       rdata_s1;
	logic            fwd_s1;
	map_word_t       fwd_data_s1;
	logic            s1_advance;

	// Stage one datapath.
	map_word_t       cur_word;
	map_word_t       lowest;
	logic [BIT_W-1:0] found_bit;
	logic            wr_en;
	logic            wr_go;
	map_word_t       wr_data;
	logic [INDEX_W-1:0] res_index;
	status_t         res_status;

	// Response register.
	logic            m_valid_q;
	logic [INDEX_W-1:0] m_index_q;
	status_t         m_status_q;

	assign s1_advance = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready   = !clearing_q && (!valid_s1 || s1_advance);
	assign accept     = s_tvalid && s_tready;

	assign in_action = action_t'(s_tuser[0]);
	assign in_index  = s_tdata[INDEX_W-1:0];
	assign rel_word  = in_index[INDEX_W-1:BIT_W];
	assign rel_ok    = int'(rel_word) < WORDS;
	assign ptr_next  = (ptr_q == LAST_WORD) ? '0 : ptr_q + 1'b1;
	assign rd_addr   = (in_action == ACT_ALLOC) ? ptr_next : AW'(rel_word);

	// The word that stage one works on: freshly written data wins over the stale read.
	assign cur_word = fwd_s1 ? fwd_data_s1 : rdata_s1;
	// Isolate the lowest free bit, then encode its position.
	assign lowest   = cur_word & (~cur_word + map_word_t'(1));

	always_comb begin
		found_bit = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (lowest[i]) begin
				found_bit = found_bit | BIT_W'(i);
			end
		end
	end

	always_comb begin
		wr_en      = 1'b0;
		wr_data    = cur_word;
		res_index  = '0;
		res_status = STATUS_OK;
		case (action_s1)
			ACT_RELEASE: begin
				// Releases of words beyond the store are dropped.
				wr_en   = rel_ok_s1;
				wr_data = cur_word | (map_word_t'(1) << bit_s1);
			end
			ACT_ALLOC: begin
				if (cur_word == '0) begin
					res_status = STATUS_EXHAUSTED;
				end else begin
					wr_en     = 1'b1;
					wr_data   = cur_word & (cur_word - map_word_t'(1));
					res_index = INDEX_W'({addr_s1, found_bit});
				end
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	assign wr_go = s1_advance && wr_en;

	// Store write and read ports.
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			free_map_q[clr_addr_q] <= '1;
		end else if (wr_go) begin
			free_map_q[addr_s1] <= wr_data;
		end
		if (accept) begin
			rdata_s1 <= free_map_q[rd_addr];
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
			ptr_q      <= LAST_WORD;
			valid_s1   <= 1'b0;
			m_valid_q  <= 1'b0;
		end else begin
			if (clearing_q) begin
				if (clr_addr_q == LAST_WORD) begin
					clearing_q <= 1'b0;
				end else begin
					clr_addr_q <= clr_addr_q + 1'b1;
				end
			end
			if (accept && in_action == ACT_ALLOC) begin
				ptr_q <= ptr_next;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_advance) begin
				valid_s1 <= 1'b0;
			end
			if (s1_advance) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Stage one payload, captured with the store read.
	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1   <= in_action;
			bit_s1      <= in_index[BIT_W-1:0];
			addr_s1     <= rd_addr;
			rel_ok_s1   <= rel_ok;
			fwd_s1      <= wr_go && (addr_s1 == rd_addr);
			fwd_data_s1 <= wr_data;
		end
	end

	// Response payload.
	always_ff @(posedge clk) begin
		if (s1_advance) begin
			m_index_q  <= res_index;
			m_status_q <= res_status;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = TDATA_W'(m_index_q);
	assign m_tuser  = m_status_q;

endmodule

// ----- bench/tb_rotating_bitmap_index_allocator.sv -----
// Self-checking testbench for the rotating bitmap index allocator.
`timescale 1ns / 1ps

module tb_rotating_bitmap_index_allocator;
	import rbia_pkg::*;

	localparam int WORDS      = 64;
	localparam int HALF_CLK   = 4;
	localparam int QUIET_MAX  = 1000;  // cycles with no transaction on either side
	localparam int SETTLE     = 20;    // cycles watched after the last response
	localparam int MAX_REPORT = 10;

	// Idling schemes applied to the request and response sides.
	typedef enum int {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_t;

	// One response as the allocator should return it.
	typedef struct packed {
		logic [INDEX_W-1:0] index;
		status_t            status;
	} grant_t;

	// A directed request. Rows with known set carry a hand-written response; the
	// others are checked against the allocator model below.
	typedef struct packed {
		action_t            act;
		logic [INDEX_W-1:0] index;
		logic               known;
		logic [INDEX_W-1:0] want_index;
		status_t            want_status;
	} script_row_t;

	localparam int N_ROWS = 14;

	// After reset the word pointer sits on the last word, so the allocates walk words 0, 1,
	// 2, ... and hand out bit 0 of each. Release responses are always zero with status ok.
	localparam script_row_t SCRIPT [N_ROWS] = '{
		'{ACT_ALLOC,   12'h000, 1'b1, 12'd0,   STATUS_OK},  // word 0, bit 0
		'{ACT_ALLOC,   12'hFFF, 1'b1, 12'd64,  STATUS_OK},  // index field ignored
		'{ACT_RELEASE, 12'h000, 1'b1, 12'd0,   STATUS_OK},  // return a granted index
		'{ACT_RELEASE, 12'h000, 1'b1, 12'd0,   STATUS_OK},  // same index, already free
		'{ACT_RELEASE, 12'hFFF, 1'b1, 12'd0,   STATUS_OK},  // top index, never granted
		'{ACT_ALLOC,   12'hAAA, 1'b1, 12'd128, STATUS_OK},
		'{ACT_RELEASE, 12'h040, 1'b1, 12'd0,   STATUS_OK},
		'{ACT_ALLOC,   12'h555, 1'b1, 12'd192, STATUS_OK},
		'{ACT_RELEASE, 12'h0C0, 1'b1, 12'd0,   STATUS_OK},
		'{ACT_RELEASE, 12'h800, 1'b1, 12'd0,   STATUS_OK},
		'{ACT_ALLOC,   12'h000, 1'b0, 12'd0,   STATUS_OK},
		'{ACT_ALLOC,   12'hFFF, 1'b0, 12'd0,   STATUS_OK},
		'{ACT_RELEASE, 12'h7FF, 1'b1, 12'd0,   STATUS_OK},
		'{ACT_ALLOC,   12'h000, 1'b0, 12'd0,   STATUS_OK}
	};

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata;
	logic [0:0]         s_tuser;
	logic               m_tvalid;
	logic               m_tready;
	logic [TDATA_W-1:0] m_tdata;
	logic [0:0]         m_tuser;

	// Allocator model state: one free bit per index, and the word pointer.
	map_word_t          free_map [WORDS];
	int                 word_ptr;

	grant_t             pending_grants [$];  // responses still owed by the block
	logic [INDEX_W-1:0] held_index [$];      // indices granted and not yet returned
	idle_mode_t         idle_mode;
	int                 errors;
	int                 quiet;
	grant_t             oldest;

	rotating_bitmap_index_allocator #(
		.WORDS(WORDS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),   // [11:0] release_index, [15:12] zero
		.s_tuser (s_tuser),   // [0] action
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),   // [11:0] granted_index, [15:12] zero
		.m_tuser (m_tuser)    // [0] status
	);

	initial clk = 1'b0;
	always #(HALF_CLK) clk = ~clk;

	// Applies one request to the model and returns the response it must produce.
	// An allocate advances the pointer first, then takes the lowest free bit of that
	// single word; a full word leaves the map alone and reports exhausted.
	function automatic grant_t allocate_or_release(input action_t act,
			input logic [INDEX_W-1:0] idx);
		grant_t     res;
		int         slot;
		int         bit_pos;
		logic       found;
		res   = '{index: '0, status: STATUS_OK};
		found = 1'b0;
		if (act == ACT_RELEASE) begin
			slot = int'(idx >> BIT_W);
			if (slot < WORDS)
				free_map[slot][idx[BIT_W-1:0]] = 1'b1;
			return res;
		end
		word_ptr = (word_ptr >= WORDS - 1) ? 0 : word_ptr + 1;
		if (free_map[word_ptr] == '0) begin
			res.status = STATUS_EXHAUSTED;
			return res;
		end
		bit_pos = 0;
		for (int b = 0; b < WORD_BITS; b++) begin
			if (!found && free_map[word_ptr][b]) begin
				bit_pos = b;
				found   = 1'b1;
			end
		end
		free_map[word_ptr][bit_pos] = 1'b0;
		res.index = INDEX_W'(word_ptr * WORD_BITS + bit_pos);
		return res;
	endfunction

	function automatic int send_idle_pct(input idle_mode_t mode);
		case (mode)
			IDLE_SEND: return 64;
			IDLE_BOTH: return 25;
			default:   return 0;
		endcase
	endfunction

	function automatic int recv_stall_pct(input idle_mode_t mode);
		case (mode)
			IDLE_RECV: return 64;
			IDLE_BOTH: return 25;
			default:   return 0;
		endcase
	endfunction

	// Presents one request, entered and left just after a falling edge. Valid stays high
	// from one request to the next unless an idle cycle is rolled, so it is written at most
	// once per step. The model runs at the rising edge that accepts the transaction.
	task automatic send_request(input action_t act, input logic [INDEX_W-1:0] idx,
			input logic known, input grant_t typed);
		grant_t got;
		while ($urandom_range(0, 99) < send_idle_pct(idle_mode)) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = TDATA_W'(idx);
		s_tuser  = act;
		do
			@(posedge clk);
		while (!s_tready);
		got = allocate_or_release(act, idx);
		pending_grants.push_back(known ? typed : got);
		if (act == ACT_ALLOC && got.status == STATUS_OK)
			held_index.push_back(got.index);
		@(negedge clk);
	endtask

	// Random requests. Most releases hand back an index that is really held, the rest
	// pick any index, free or not. At the end the request side waits for every response.
	task automatic run_phase(input idle_mode_t mode, input int count, input int alloc_pct);
		action_t            act;
		logic [INDEX_W-1:0] idx;
		int                 pos;
		idle_mode = mode;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 99) < alloc_pct) begin
				act = ACT_ALLOC;
				idx = INDEX_W'($urandom_range(0, 4095));
			end else begin
				act = ACT_RELEASE;
				if (held_index.size() != 0 && $urandom_range(0, 99) < 70) begin
					pos = $urandom_range(0, held_index.size() - 1);
					idx = held_index[pos];
					held_index.delete(pos);
				end else begin
					idx = INDEX_W'($urandom_range(0, 4095));
				end
			end
			send_request(act, idx, 1'b0, '0);
		end
		s_tvalid = 1'b0;
		while (pending_grants.size() != 0)
			@(negedge clk);
	endtask

	// The response side rolls its ready once per cycle at the falling edge.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct(idle_mode));
	end

	// Response checker: every accepted response is matched against the oldest one owed.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_grants.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORT)
					$display("%0t: response with none outstanding: index %0d status %0d",
						$realtime, m_tdata, m_tuser);
			end else begin
				oldest = pending_grants.pop_front();
				if (m_tdata !== TDATA_W'(oldest.index) || m_tuser[0] !== oldest.status) begin
					errors++;
					if (errors <= MAX_REPORT)
						$display("%0t: expected index %0d status %0d, got index %0d status %0d",
							$realtime, oldest.index, oldest.status, m_tdata, m_tuser);
				end
			end
		end
	end

	// Watchdog: a run that stops moving ends here. The clearing pass after reset and the
	// longest random stalls are far below the limit.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= QUIET_MAX) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = ACT_ALLOC;
		m_tready  = 1'b0;
		idle_mode = IDLE_NONE;
		errors    = 0;
		quiet     = 0;
		word_ptr  = WORDS - 1;
		foreach (free_map[w])
			free_map[w] = '1;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part with the pointer and map fresh from reset.
		foreach (SCRIPT[r])
			send_request(SCRIPT[r].act, SCRIPT[r].index, SCRIPT[r].known,
				'{index: SCRIPT[r].want_index, status: SCRIPT[r].want_status});

		// Mixed traffic under each idling scheme.
		run_phase(IDLE_NONE, 280, 50);
		run_phase(IDLE_SEND, 280, 55);
		run_phase(IDLE_RECV, 280, 55);
		run_phase(IDLE_BOTH, 280, 50);

		// Allocate only, so every word in turn gives up its next free bit and the
		// lowest free bit climbs higher in each word.
		run_phase(IDLE_NONE, 300, 100);

		// Scattered releases then make the lowest free bit land anywhere.
		run_phase(IDLE_BOTH, 150, 50);
		run_phase(IDLE_RECV, 116, 50);

		repeat (SETTLE) @(posedge clk);
		if (errors == 0 && pending_grants.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
